// ===== rtl/uef_pkg.sv =====
// ----------------------------------------------------------------------------
// uef_pkg
// Shared types, constants and the emoji range test for the UTF-8 emoji filter.
// ----------------------------------------------------------------------------
`default_nettype none

package uef_pkg;

   // Sequence lengths; zero means no sequence is open.
   localparam logic [2:0] SeqNone  = 3'd0;
   localparam logic [2:0] SeqTwo   = 3'd2;
   localparam logic [2:0] SeqThree = 3'd3;
   localparam logic [2:0] SeqFour  = 3'd4;

   localparam logic [7:0] ReplacementReset = 8'h3F;

   localparam int MaxResults   = 4;
   localparam int QueueDepth   = 8;
   localparam int PtrWidth     = $clog2(QueueDepth);
   localparam int CountWidth   = $clog2(QueueDepth + 1);
   // Input is held back while the queue cannot take a full group of results.
   localparam int QueueRoomMax = QueueDepth - MaxResults;

   // Results caused by one input byte.
   typedef struct packed {
      logic [2:0]                 count;
      logic [MaxResults-1:0][7:0] data;
      logic                       string_end;
   } result_group_type;

   // One word of the result queue.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       out_end;
   } queue_word_type;

   function automatic logic is_emoji(input logic [20:0] cp);
      logic hit;
      hit = (cp == 21'h0200D) || (cp == 21'h020E3) || (cp == 21'h0FE0F)
         || ((cp >= 21'h1F000) && (cp <= 21'h1FAFF))
         || ((cp >= 21'h02600) && (cp <= 21'h026FF))
         || ((cp >= 21'h02700) && (cp <= 21'h027BF))
         || ((cp >= 21'h0FE00) && (cp <= 21'h0FE0F));
      return hit;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/uef_seq.sv =====
// ----------------------------------------------------------------------------
// uef_seq
// Sequence tracker and decoder: holds the open UTF-8 sequence and forms the
// group of result words for each byte it steps on.
// ----------------------------------------------------------------------------
`default_nettype none

module uef_seq (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      step,
   input  wire logic [7:0]                in_byte,
   input  wire logic                      in_end,
   input  wire logic [7:0]                repl_byte,
   output      uef_pkg::result_group_type group
);
   import uef_pkg::*;

   logic [2:0]       seq_len_ff, seq_len_in;
   logic [1:0]       held_cnt_ff, held_cnt_in;
   logic [2:0][7:0]  held_ff;
   logic [2:0]       lead_len;
   logic             complete;
   logic [20:0]      cp;
   logic             hold;
   logic             hold_lead;
   result_group_type grp;

   always_comb begin
      if ((in_byte & 8'hE0) == 8'hC0) begin
         lead_len = SeqTwo;
      end else if ((in_byte & 8'hF0) == 8'hE0) begin
         lead_len = SeqThree;
      end else if ((in_byte & 8'hF8) == 8'hF0) begin
         lead_len = SeqFour;
      end else begin
         lead_len = SeqNone;
      end
   end

   assign complete = (seq_len_ff != SeqNone) && (({1'b0, held_cnt_ff} + 3'd1) >= seq_len_ff);

   always_comb begin
      case (seq_len_ff)
         SeqTwo: begin
            cp = {10'd0, held_ff[0][4:0], in_byte[5:0]};
         end
         SeqThree: begin
            cp = {5'd0, held_ff[0][3:0], held_ff[1][5:0], in_byte[5:0]};
         end
         default: begin
            cp = {held_ff[0][2:0], held_ff[1][5:0], held_ff[2][5:0], in_byte[5:0]};
         end
      endcase
   end

   always_comb begin
      grp            = '0;
      grp.string_end = in_end;
      hold           = 1'b0;
      hold_lead      = 1'b0;
      seq_len_in     = seq_len_ff;
      held_cnt_in    = held_cnt_ff;
      if (seq_len_ff == SeqNone) begin
         if ((lead_len == SeqNone) || in_end) begin
            grp.count   = 3'd1;
            grp.data[0] = in_byte;
         end else begin
            hold_lead   = 1'b1;
            seq_len_in  = lead_len;
            held_cnt_in = 2'd1;
         end
      end else if (complete && is_emoji(cp)) begin
         grp.count   = 3'd1;
         grp.data[0] = repl_byte;
         seq_len_in  = SeqNone;
         held_cnt_in = 2'd0;
      end else if (complete || in_end) begin
         // Emit the held bytes raw, then the current byte.
         grp.count   = {1'b0, held_cnt_ff} + 3'd1;
         grp.data[0] = (held_cnt_ff > 2'd0) ? held_ff[0] : in_byte;
         grp.data[1] = (held_cnt_ff > 2'd1) ? held_ff[1] : in_byte;
         grp.data[2] = (held_cnt_ff > 2'd2) ? held_ff[2] : in_byte;
         grp.data[3] = in_byte;
         seq_len_in  = SeqNone;
         held_cnt_in = 2'd0;
      end else begin
         hold        = 1'b1;
         held_cnt_in = held_cnt_ff + 2'd1;
      end
      if (!step) begin
         grp.count = 3'd0;
      end
   end

   assign group = grp;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_len_ff  <= SeqNone;
         held_cnt_ff <= 2'd0;
      end else if (step) begin
         seq_len_ff  <= seq_len_in;
         held_cnt_ff <= held_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && hold_lead) begin
         held_ff[0] <= in_byte;
      end
      if (step && hold) begin
         if (held_cnt_ff == 2'd1) begin
            held_ff[1] <= in_byte;
         end else begin
            held_ff[2] <= in_byte;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/uef_outq.sv =====
// ----------------------------------------------------------------------------
// uef_outq
// Result queue: takes up to four words in a cycle and hands out one a cycle while pop is high.
// ----------------------------------------------------------------------------
`default_nettype none

module uef_outq (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire uef_pkg::result_group_type         group,
   input  wire logic                              pop,
   output      uef_pkg::queue_word_type           head,
   output      logic [uef_pkg::CountWidth-1:0]    count
);
   import uef_pkg::*;

   queue_word_type              words_ff [QueueDepth];
   logic [PtrWidth-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]       count_ff, count_in;

   assign wr_ptr_in = wr_ptr_ff + PtrWidth'(group.count);
   assign rd_ptr_in = rd_ptr_ff + PtrWidth'(pop);
   assign count_in  = count_ff + CountWidth'(group.count) - CountWidth'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MaxResults; k++) begin
         if (3'(k) < group.count) begin
            words_ff[wr_ptr_ff + PtrWidth'(k)] <= '{
               out_byte: group.data[k],
               run_last: (3'(k + 1) == group.count),
               out_end:  (3'(k + 1) == group.count) && group.string_end
            };
         end
      end
   end

   assign head  = words_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

`default_nettype wire

// ===== rtl/utf8_emoji_filter_core.sv =====
// ----------------------------------------------------------------------------
// utf8_emoji_filter_core
// Replaces emoji code points in a UTF-8 byte stream by one configurable byte
// and passes every other byte through unchanged.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Word
//   req_      in         req_valid/req_stall   in_byte, string_end
//   rsp_      out        rsp_valid/rsp_stall   out_byte, run_last, out_end
//   csr_      in         csr_wr_en             replacement byte
//
// A byte is taken every cycle while req_stall is low; its result words pass
// through the input register, then the result queue.
// A byte yields zero to four result words, which leave one per cycle while rsp_stall is low.
// req_stall rises while an input byte waits and the queue holds more than four
// words, so a stalled rsp_ side backs up into the req_ side.
// Reset is synchronous; it clears the open sequence, the queue and the
// replacement byte (back to a question mark).
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_emoji_filter_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_string_end,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [7:0] rsp_out_byte,
   output      logic       rsp_run_last,
   output      logic       rsp_out_end,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data
);
   import uef_pkg::*;

   // Replacement byte register.
   logic [7:0]            repl_ff;

   // Input register: one accepted byte waiting to be decoded.
   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_end_ff;

   logic                  req_accept;
   logic                  advance;
   logic                  room;
   logic                  pop;
   logic [CountWidth-1:0] q_count;
   result_group_type      group;
   queue_word_type        head;

   always_ff @(posedge clock) begin
      if (reset) begin
         repl_ff <= ReplacementReset;
      end else if (csr_wr_en) begin
         repl_ff <= csr_wr_data;
      end
   end

   // The held byte moves on only when the queue can take a full group.
   assign room       = (q_count <= CountWidth'(QueueRoomMax));
   assign advance    = in_valid_ff && room;
   assign req_stall  = in_valid_ff && !room;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_in_byte;
         in_end_ff  <= req_string_end;
      end
   end

   // Decoding happens in the cycle the byte leaves the input register.
   uef_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .in_byte   (in_byte_ff),
      .in_end    (in_end_ff),
      .repl_byte (repl_ff),
      .group     (group)
   );

   uef_outq u_outq (
      .clock (clock),
      .reset (reset),
      .group (group),
      .pop   (pop),
      .head  (head),
      .count (q_count)
   );

   // The head word holds still while the queue is stalled.
   assign rsp_valid    = (q_count != '0);
   assign pop          = rsp_valid && !rsp_stall;
   assign rsp_out_byte = head.out_byte;
   assign rsp_run_last = head.run_last;
   assign rsp_out_end  = head.out_end;

endmodule

`default_nettype wire

// ===== rtl/uef_checker.sv =====
// ----------------------------------------------------------------------------
// uef_checker
// Port-level checks on the emoji filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module uef_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_run_last,
   input wire logic       rsp_out_end
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // A stalled result keeps its byte.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_byte))
      else $error("rsp_out_byte changed while stalled");

   // The end of a string is always the last word of its input byte.
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_end |-> rsp_run_last)
      else $error("out_end without run_last");

   // Reset empties the result queue.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // With nothing offered and no byte accepted now or before, no result can appear.
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && !req_stall) && !$past(req_valid && !req_stall)
      |=> !rsp_valid)
      else $error("result appeared without input");

endmodule

bind utf8_emoji_filter_core uef_checker u_uef_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte),
   .rsp_run_last (rsp_run_last),
   .rsp_out_end  (rsp_out_end)
);

`default_nettype wire
